FILE: hdl/spr_pkg.sv
`default_nettype none
package spr_pkg;

  // Default values of the top level parameters
  localparam int unsigned RECALC_PERIOD_US_DEF = 100000;
  localparam int unsigned EXP_TABLE_DEPTH_DEF  = 256;

  // Field widths
  localparam int unsigned REQ_W      = 2;
  localparam int unsigned TICK_W     = 20;
  localparam int unsigned PWR_W      = 15;
  localparam int unsigned SPP_W      = 13;
  localparam int unsigned START_W    = 7;
  localparam int unsigned SHAPE_W    = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 13;

  // Shared divider widths
  localparam int unsigned DIV_NW = 58;
  localparam int unsigned DIV_DW = 46;

  // Arithmetic constants
  localparam logic [PWR_W-1:0] FULL_SCALE = 15'd25600;
  localparam logic [45:0]      ONE_Q24    = 46'd16777216;
  localparam logic [63:0]      LN2_Q32    = 64'd2977044472;
  localparam logic [32:0]      LOG2E_Q32  = 33'd6196328019;
  localparam logic [19:0]      US_PER_S   = 20'd1000000;
  localparam logic [4:0]       MAX_SHIFT  = 5'd20;

  // ceil(LOG2E_Q32 * 2^48 / 65536000): exponent is (mag * p * EXP_RECIP) >> 48,
  // exact for every mag * p below 2^22
  localparam logic [54:0] EXP_RECIP    =
    55'(((128'(LOG2E_Q32) << 29) + 128'd124) / 128'd125);
  localparam logic [27:0] EXP_RECIP_LO = EXP_RECIP[27:0];
  localparam logic [26:0] EXP_RECIP_HI = EXP_RECIP[54:28];

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_START = 2'd1,
    REQ_RESET = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    CFG_SECONDS_PER_PERCENT = 2'd0,
    CFG_START_LEVEL         = 2'd1,
    CFG_SHAPE_TENTHS        = 2'd2
  } cfg_idx_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_UPDATE,
    OP_RC_MUL,
    OP_RC_DIV,
    OP_RC_END,
    OP_PW_CHK,
    OP_SH_INIT,
    OP_SH_MUL,
    OP_SH_DIV,
    OP_SH_POW,
    OP_SH_SHIFT,
    OP_SH_NUM,
    OP_SH_END,
    OP_OUT
  } dp_op_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_UPDATE,
    S_RC_MUL,
    S_RC_DIV,
    S_RC_WAIT,
    S_RC_END,
    S_PW_CHK,
    S_SH_INIT,
    S_SH_MUL,
    S_SH_DIV,
    S_SH_POW,
    S_SH_SHIFT,
    S_SH_NUM,
    S_SH_NWAIT,
    S_SH_END,
    S_DONE
  } ctrl_state_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic recalc_due;
    logic shaped;
    logic pass;
  } dp_status_t;

  // One entry of the Q30 table of 2^(i/depth); v is i*ln2/depth in Q32
  function automatic logic [31:0] pow2_entry(logic [31:0] v);
    logic [63:0] sum;
    logic [63:0] term;
    sum  = 64'h1_0000_0000;
    term = 64'h1_0000_0000;
    for (int n = 1; n <= 24; n++) begin
      term = ((term * 64'(v)) >> 32) / 64'(n);
      sum  = sum + term;
    end
    return sum[33:2];
  endfunction

endpackage
`default_nettype wire

FILE: hdl/spr_if.sv
`default_nettype none
interface spr_in_if;
  logic                           valid;
  logic                           ready;
  logic [spr_pkg::REQ_W-1:0]      req_type;
  logic [spr_pkg::TICK_W-1:0]     tick_us;

  modport source(output valid, req_type, tick_us, input ready);
  modport sink(input valid, req_type, tick_us, output ready);
endinterface

interface spr_out_if;
  logic                           valid;
  logic                           ready;
  logic [spr_pkg::PWR_W-1:0]      power_percent;
  logic                           ramp_active;
  logic                           recalculated;

  modport source(output valid, power_percent, ramp_active, recalculated, input ready);
  modport sink(input valid, power_percent, ramp_active, recalculated, output ready);
endinterface
`default_nettype wire

FILE: hdl/shaped_power_ramp_generator_unit.sv
`default_nettype none
// Shaped power ramp generator. Each accepted item (time tick, ramp start or
// block reset) yields exactly one result item with the shaped power level in
// 1/256 percent, the ramp-active flag and a flag telling whether this tick
// ended a recalculation period. Items are handled one at a time: each is
// loaded and updated, a start or a tick past the period while running then
// recalculates the progress, and exponential shaping follows while the ramp
// runs with a nonzero shape. A shared 58-step restoring divider serves once
// for the progress and once for the shaped ratio; the exponent scaling is a
// reciprocal multiplication split into low and high halves. A finished result
// sits in an output register, so the next item is accepted while it waits.
// The user must write configuration through cfg_we, cfg_index and cfg_data
// only while no item is in flight; the block does not enforce it.
module shaped_power_ramp_generator_unit #(
  parameter int unsigned RECALC_PERIOD_US = spr_pkg::RECALC_PERIOD_US_DEF,
  parameter int unsigned EXP_TABLE_DEPTH  = spr_pkg::EXP_TABLE_DEPTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [spr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [spr_pkg::CFG_DATA_W-1:0]    cfg_data,
  spr_in_if.sink                                 requests,
  spr_out_if.source                              results
);

  spr_pkg::dp_cmd_t    cmd;
  spr_pkg::dp_status_t status;

  spr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (requests.valid),
    .in_ready (requests.ready),
    .out_ready(results.ready),
    .out_valid(results.valid),
    .status   (status),
    .cmd      (cmd)
  );

  spr_dp #(
    .RECALC_PERIOD_US(RECALC_PERIOD_US),
    .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_req_type  (requests.req_type),
    .in_tick_us   (requests.tick_us),
    .cmd          (cmd),
    .status       (status),
    .power_percent(results.power_percent),
    .ramp_active  (results.ramp_active),
    .recalculated (results.recalculated)
  );

endmodule
`default_nettype wire

FILE: hdl/spr_div.sv
`default_nettype none
module spr_div #(
  parameter int unsigned NW = spr_pkg::DIV_NW,
  parameter int unsigned DW = spr_pkg::DIV_DW
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [NW-1:0] dividend,
  input  wire logic [DW-1:0] divisor,
  output logic               busy,
  output logic [NW-1:0]      quotient
);

  localparam int unsigned CNT_W = $clog2(NW + 1);

  logic [CNT_W-1:0] cnt;
  logic [DW:0]      rem;
  logic [NW-1:0]    num;
  logic [DW-1:0]    dsr;
  logic [DW:0]      trial;
  logic             fits;

  // One quotient bit a cycle, restoring
  always_comb begin
    trial = {rem[DW-1:0], num[NW-1]};
    fits  = (trial >= {1'b0, dsr});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(NW);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      num <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      rem <= fits ? (trial - {1'b0, dsr}) : trial;
      num <= {num[NW-2:0], fits};
    end
  end

  assign quotient = num;

endmodule
`default_nettype wire

FILE: hdl/spr_dp.sv
`default_nettype none
module spr_dp #(
  parameter int unsigned RECALC_PERIOD_US = spr_pkg::RECALC_PERIOD_US_DEF,
  parameter int unsigned EXP_TABLE_DEPTH  = spr_pkg::EXP_TABLE_DEPTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [spr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [spr_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire logic [spr_pkg::REQ_W-1:0]         in_req_type,
  input  wire logic [spr_pkg::TICK_W-1:0]        in_tick_us,
  input  wire spr_pkg::dp_cmd_t                  cmd,
  output spr_pkg::dp_status_t                    status,
  output logic [spr_pkg::PWR_W-1:0]              power_percent,
  output logic                                   ramp_active,
  output logic                                   recalculated
);

  localparam int unsigned IDX_W = $clog2(EXP_TABLE_DEPTH + 1);
  localparam int unsigned SCL_W = 24 + IDX_W;
  localparam int unsigned NW    = spr_pkg::DIV_NW;
  localparam int unsigned DW    = spr_pkg::DIV_DW;

  // Constant table of 2^(i/depth) in Q30
  logic [31:0] pow2_tab [EXP_TABLE_DEPTH+1];
  for (genvar gi = 0; gi <= EXP_TABLE_DEPTH; gi++) begin : g_tab
    localparam logic [31:0] ARG =
      32'((64'(gi) * spr_pkg::LN2_Q32) / 64'(EXP_TABLE_DEPTH));
    localparam logic [31:0] ENTRY = spr_pkg::pow2_entry(ARG);
    assign pow2_tab[gi] = ENTRY;
  end

  // Configuration
  logic [spr_pkg::SPP_W-1:0]   spp;
  logic [spr_pkg::START_W-1:0] start_lvl;
  logic [spr_pkg::SHAPE_W-1:0] shape;

  // Block state
  spr_pkg::req_t               req;
  logic [spr_pkg::TICK_W-1:0]  tick;
  logic [31:0]                 ess;
  logic [31:0]                 esc;
  logic                        running;
  logic [spr_pkg::PWR_W-1:0]   prog;
  logic                        did_calc;

  // Work registers
  logic [42:0]                 usp;
  logic [7:0]                  mag;
  logic                        neg;
  logic [spr_pkg::PWR_W-1:0]   pin;
  logic                        pass;
  logic [21:0]                 mprod;
  logic [49:0]                 xs;
  logic [31:0]                 y;
  logic [55:0]                 iprod;
  logic [31:0]                 lo_r;
  logic [4:0]                  ip;
  logic [45:0]                 nval;
  logic [45:0]                 dval;
  logic [spr_pkg::PWR_W-1:0]   shaped;

  // Divider hookup
  logic                        div_start;
  logic [NW-1:0]               div_num;
  logic [DW-1:0]               div_den;
  logic                        div_busy;
  logic [NW-1:0]               div_q;

  // Combinational helpers
  logic [32:0]                 ess_sum;
  logic [32:0]                 esc_sum;
  logic [31:0]                 ess_n;
  logic [31:0]                 esc_n;
  logic                        esc_over;
  logic [21:0]                 prog_sum;
  logic                        prog_over;
  logic [spr_pkg::PWR_W-1:0]   pv;
  logic [SCL_W-1:0]            scaled;
  logic [IDX_W-1:0]            idx;
  logic [23:0]                 frac_rem;
  logic [31:0]                 tab_lo;
  logic [31:0]                 tab_hi;
  logic [31:0]                 interp;
  logic [45:0]                 pw;
  logic [spr_pkg::PWR_W-1:0]   r_val;

  always_comb begin
    ess_sum   = {1'b0, ess} + 33'(tick);
    esc_sum   = {1'b0, esc} + 33'(tick);
    ess_n     = ess_sum[32] ? 32'hFFFF_FFFF : ess_sum[31:0];
    esc_n     = esc_sum[32] ? 32'hFFFF_FFFF : esc_sum[31:0];
    esc_over  = (esc_n > 32'(RECALC_PERIOD_US));
    prog_sum  = 22'(div_q[20:0]) + 22'({start_lvl, 8'd0});
    prog_over = (usp == '0) || (|div_q[NW-1:21]) ||
                (prog_sum > 22'(spr_pkg::FULL_SCALE));
    pv        = pass ? spr_pkg::FULL_SCALE : pin;
    scaled    = SCL_W'(y[23:0]) * SCL_W'(EXP_TABLE_DEPTH);
    idx       = IDX_W'(scaled >> 24);
    frac_rem  = scaled[23:0];
    tab_lo    = pow2_tab[idx];
    tab_hi    = pow2_tab[idx + 1'b1];
    interp    = lo_r + 32'(iprod >> 24);
    pw        = 46'((64'(interp) << ip) >> 6);
    if (dval == '0) begin
      r_val = pin;
    end else if (div_q > NW'(spr_pkg::FULL_SCALE)) begin
      r_val = spr_pkg::FULL_SCALE;
    end else begin
      r_val = div_q[spr_pkg::PWR_W-1:0];
    end
  end

  // Select divider operands for each use
  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    case (cmd.op)
      spr_pkg::OP_RC_DIV: begin
        div_start = 1'b1;
        div_num   = NW'({ess, 8'd0});
        div_den   = DW'(usp);
      end
      spr_pkg::OP_SH_NUM: begin
        div_start = 1'b1;
        div_num   = NW'(61'(nval) * 61'(spr_pkg::FULL_SCALE)) + NW'(dval >> 1);
        div_den   = DW'(dval);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  spr_div #(
    .NW(NW),
    .DW(DW)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(div_num),
    .divisor (div_den),
    .busy    (div_busy),
    .quotient(div_q)
  );

  // Configuration writes and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      spp       <= spr_pkg::SPP_W'(1);
      start_lvl <= '0;
      shape     <= '0;
      ess       <= '0;
      esc       <= '0;
      running   <= 1'b0;
      prog      <= '0;
      did_calc  <= 1'b0;
      pass      <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (spr_pkg::cfg_idx_t'(cfg_index))
          spr_pkg::CFG_SECONDS_PER_PERCENT: spp       <= cfg_data;
          spr_pkg::CFG_START_LEVEL:         start_lvl <= cfg_data[spr_pkg::START_W-1:0];
          spr_pkg::CFG_SHAPE_TENTHS:        shape     <= cfg_data[spr_pkg::SHAPE_W-1:0];
          default: ;
        endcase
      end
      case (cmd.op)
        spr_pkg::OP_UPDATE: begin
          unique case (req)
            spr_pkg::REQ_TICK: begin
              ess      <= ess_n;
              esc      <= esc_over ? '0 : esc_n;
              did_calc <= esc_over;
            end
            spr_pkg::REQ_START: begin
              ess      <= '0;
              running  <= 1'b1;
              prog     <= '0;
              did_calc <= 1'b0;
            end
            spr_pkg::REQ_RESET: begin
              ess      <= '0;
              esc      <= '0;
              running  <= 1'b0;
              prog     <= '0;
              did_calc <= 1'b0;
            end
            default: begin
              did_calc <= 1'b0;
            end
          endcase
        end
        spr_pkg::OP_RC_END: begin
          if (prog_over) begin
            prog    <= spr_pkg::FULL_SCALE;
            running <= 1'b0;
          end else begin
            prog <= prog_sum[spr_pkg::PWR_W-1:0];
          end
        end
        spr_pkg::OP_PW_CHK:   pass <= 1'b0;
        spr_pkg::OP_SH_SHIFT: pass <= ~pass;
        default: ;
      endcase
    end
  end

  // Datapath payload registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      spr_pkg::OP_LOAD: begin
        req  <= spr_pkg::req_t'(in_req_type);
        tick <= in_tick_us;
      end
      spr_pkg::OP_RC_MUL: usp <= 43'(spp) * 43'(spr_pkg::US_PER_S);
      spr_pkg::OP_PW_CHK: begin
        neg <= shape[spr_pkg::SHAPE_W-1];
        mag <= shape[spr_pkg::SHAPE_W-1] ? (8'd0 - shape) : shape;
        pin <= shape[spr_pkg::SHAPE_W-1] ? (spr_pkg::FULL_SCALE - prog) : prog;
      end
      spr_pkg::OP_SH_INIT: mprod <= 22'(23'(mag) * 23'(pv));
      // Exponent by reciprocal multiplication, low and high halves
      spr_pkg::OP_SH_MUL:  xs <= 50'(mprod) * 50'(spr_pkg::EXP_RECIP_LO);
      spr_pkg::OP_SH_DIV:
        y <= 32'((49'(mprod) * 49'(spr_pkg::EXP_RECIP_HI) + 49'(xs >> 28)) >> 20);
      spr_pkg::OP_SH_POW: begin
        iprod <= 56'(tab_hi - tab_lo) * 56'(frac_rem);
        lo_r  <= tab_lo;
        ip    <= (y[31:24] > 8'(spr_pkg::MAX_SHIFT)) ? spr_pkg::MAX_SHIFT : y[28:24];
      end
      spr_pkg::OP_SH_SHIFT: begin
        if (pass) begin
          dval <= pw - spr_pkg::ONE_Q24;
        end else begin
          nval <= pw - spr_pkg::ONE_Q24;
        end
      end
      spr_pkg::OP_SH_END: shaped <= neg ? (spr_pkg::FULL_SCALE - r_val) : r_val;
      spr_pkg::OP_OUT: begin
        if (!running) begin
          power_percent <= spr_pkg::FULL_SCALE;
        end else if (shape == '0) begin
          power_percent <= prog;
        end else begin
          power_percent <= shaped;
        end
        ramp_active  <= running;
        recalculated <= did_calc;
      end
      default: ;
    endcase
  end

  // A start always recalculates; a tick only past the period while running
  always_comb begin
    status.div_busy   = div_busy;
    status.recalc_due = (req == spr_pkg::REQ_START) ||
                        ((req == spr_pkg::REQ_TICK) && esc_over && running);
    status.shaped     = running && (shape != '0);
    status.pass       = pass;
  end

endmodule
`default_nettype wire

FILE: hdl/spr_ctrl.sv
`default_nettype none
module spr_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 out_ready,
  output logic                      out_valid,
  input  wire spr_pkg::dp_status_t  status,
  output spr_pkg::dp_cmd_t          cmd
);

  spr_pkg::ctrl_state_t state;
  spr_pkg::ctrl_state_t state_next;
  logic                 out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= spr_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Sequence one item through update, recalculation and shaping
  always_comb begin
    state_next = state;
    cmd.op     = spr_pkg::OP_NONE;
    in_ready   = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      spr_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op     = spr_pkg::OP_LOAD;
          state_next = spr_pkg::S_UPDATE;
        end
      end
      spr_pkg::S_UPDATE: begin
        cmd.op = spr_pkg::OP_UPDATE;
        if (status.recalc_due) begin
          state_next = spr_pkg::S_RC_MUL;
        end else begin
          state_next = spr_pkg::S_PW_CHK;
        end
      end
      spr_pkg::S_RC_MUL: begin
        cmd.op     = spr_pkg::OP_RC_MUL;
        state_next = spr_pkg::S_RC_DIV;
      end
      spr_pkg::S_RC_DIV: begin
        cmd.op     = spr_pkg::OP_RC_DIV;
        state_next = spr_pkg::S_RC_WAIT;
      end
      spr_pkg::S_RC_WAIT: begin
        if (!status.div_busy) begin
          state_next = spr_pkg::S_RC_END;
        end
      end
      spr_pkg::S_RC_END: begin
        cmd.op     = spr_pkg::OP_RC_END;
        state_next = spr_pkg::S_PW_CHK;
      end
      spr_pkg::S_PW_CHK: begin
        cmd.op = spr_pkg::OP_PW_CHK;
        if (status.shaped) begin
          state_next = spr_pkg::S_SH_INIT;
        end else begin
          state_next = spr_pkg::S_DONE;
        end
      end
      spr_pkg::S_SH_INIT: begin
        cmd.op     = spr_pkg::OP_SH_INIT;
        state_next = spr_pkg::S_SH_MUL;
      end
      spr_pkg::S_SH_MUL: begin
        cmd.op     = spr_pkg::OP_SH_MUL;
        state_next = spr_pkg::S_SH_DIV;
      end
      spr_pkg::S_SH_DIV: begin
        cmd.op     = spr_pkg::OP_SH_DIV;
        state_next = spr_pkg::S_SH_POW;
      end
      spr_pkg::S_SH_POW: begin
        cmd.op     = spr_pkg::OP_SH_POW;
        state_next = spr_pkg::S_SH_SHIFT;
      end
      spr_pkg::S_SH_SHIFT: begin
        cmd.op = spr_pkg::OP_SH_SHIFT;
        if (status.pass) begin
          state_next = spr_pkg::S_SH_NUM;
        end else begin
          state_next = spr_pkg::S_SH_INIT;
        end
      end
      spr_pkg::S_SH_NUM: begin
        cmd.op     = spr_pkg::OP_SH_NUM;
        state_next = spr_pkg::S_SH_NWAIT;
      end
      spr_pkg::S_SH_NWAIT: begin
        if (!status.div_busy) begin
          state_next = spr_pkg::S_SH_END;
        end
      end
      spr_pkg::S_SH_END: begin
        cmd.op     = spr_pkg::OP_SH_END;
        state_next = spr_pkg::S_DONE;
      end
      spr_pkg::S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.op     = spr_pkg::OP_OUT;
          out_load   = 1'b1;
          state_next = spr_pkg::S_IDLE;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire
